// ----- rtl/stt_pkg.sv -----
// Shared types and constants for the session table with TTL aging.
// Used by session_table_ttl; no other dependencies.

package stt_pkg;

   localparam int KEY_W  = 64;
   localparam int TIME_W = 48;
   localparam int TTL_W  = 32;
   localparam int ROLE_W = 2;
   localparam int TAG_W  = 32;
   localparam int KIND_W = 3;

   localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(3600);

   // Request kinds carried on req_tuser.
   localparam logic [KIND_W-1:0] REQ_STORE    = 3'd0;
   localparam logic [KIND_W-1:0] REQ_VALIDATE = 3'd1;
   localparam logic [KIND_W-1:0] REQ_REMOVE   = 3'd2;
   localparam logic [KIND_W-1:0] REQ_CLEAR    = 3'd3;
   localparam logic [KIND_W-1:0] REQ_TICK     = 3'd4;

   typedef struct packed {
      logic [KEY_W-1:0]  key_high;
      logic [KEY_W-1:0]  key_low;
      logic [TIME_W-1:0] expiry;
      logic [ROLE_W-1:0] role;
      logic [TAG_W-1:0]  user;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

endpackage

// ----- rtl/session_table_ttl.sv -----
// Top level of the session table: keyed entries with time-to-live aging.
// Depends on stt_pkg (types, constants) and stt_ram (entry storage).

// A store, validate or remove with a nonzero token scans the table one entry
// per cycle through the single read port of the entry RAM and one shared key
// and expiry comparator. Each entry is judged in the cycle after its RAM read,
// and the response is loaded into the output register when the judged entry
// ends the scan. The scan stops at the first match. Clear, tick, an all-zero
// token and unused kinds load their response at the accepting edge, so it is
// presented in the next cycle. While a scan runs, req_tready is low. A new
// request is accepted once the output register is empty or being emptied in
// the same cycle. Live bits sit in flip-flops and reset clears them at once,
// so no clearing pass is needed after reset.

module session_table_ttl #(
   parameter int SESSION_ENTRIES = 8
) (
   input  logic         clock,
   input  logic         reset,
   // Request: token_high [63:0], token_low [127:64], new_role [129:128],
   // user_tag [161:130], zero fill [167:162].
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [167:0] req_tdata,
   // Request kind: req_type [2:0].
   input  logic [2:0]   req_tuser,
   // Response: success [0], session_role [2:1], out_user_tag [34:3],
   // zero fill [39:35].
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [31:0]  csr_wdata
);

   localparam int IDX_W = (SESSION_ENTRIES > 1) ? $clog2(SESSION_ENTRIES) : 1;
   localparam int CNT_W = $clog2(SESSION_ENTRIES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SESSION_ENTRIES - 1);

   // Configuration and time.
   logic [stt_pkg::TTL_W-1:0]  ttl_ff;
   logic [stt_pkg::TIME_W-1:0] time_ff, time_in;

   // Sequencer.
   stt_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   rd_cnt_ff, rd_cnt_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic               slot_vld_ff, slot_vld_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic [SESSION_ENTRIES-1:0] live_ff, live_in;

   // Latched request.
   logic [stt_pkg::KIND_W-1:0] op_ff;
   logic [stt_pkg::KEY_W-1:0]  kh_ff, kl_ff;
   logic [stt_pkg::ROLE_W-1:0] role_ff;
   logic [stt_pkg::TAG_W-1:0]  tag_ff;
   logic [stt_pkg::TIME_W-1:0] exp_ff;

   // Output register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_ok_ff, rsp_ok_in;
   logic [stt_pkg::ROLE_W-1:0] rsp_role_ff, rsp_role_in;
   logic [stt_pkg::TAG_W-1:0]  rsp_tag_ff, rsp_tag_in;
   logic                       rsp_load;

   // Request fields.
   logic [stt_pkg::KEY_W-1:0]  req_kh, req_kl;
   logic [stt_pkg::ROLE_W-1:0] req_role;
   logic [stt_pkg::TAG_W-1:0]  req_tag;
   logic                       req_fire, req_zero_key, req_scan;
   logic [stt_pkg::TIME_W:0]   exp_sum;
   logic [stt_pkg::TIME_W-1:0] exp_new;

   // Entry RAM.
   logic                         ram_we, ram_re;
   logic [IDX_W-1:0]             ram_waddr;
   stt_pkg::entry_type           ram_wdata, ent;
   logic [stt_pkg::ENTRY_W-1:0]  ram_rdata;

   // Scan evaluation.
   logic live_cur, key_match, expired, last, scan_done, live_clr, take_free;
   logic rsp_ok_scan;
   logic [stt_pkg::ROLE_W-1:0] rsp_role_scan;
   logic [stt_pkg::TAG_W-1:0]  rsp_tag_scan;

   assign req_kh   = req_tdata[63:0];
   assign req_kl   = req_tdata[127:64];
   assign req_role = req_tdata[129:128];
   assign req_tag  = req_tdata[161:130];

   assign req_tready   = (state_ff == stt_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire     = req_tvalid && req_tready;
   assign req_zero_key = (req_kh == '0) && (req_kl == '0);
   assign req_scan     = !req_zero_key && ((req_tuser == stt_pkg::REQ_STORE)
                         || (req_tuser == stt_pkg::REQ_VALIDATE)
                         || (req_tuser == stt_pkg::REQ_REMOVE));

   // Saturating expiry, computed once per request.
   assign exp_sum = {1'b0, time_ff} + (stt_pkg::TIME_W + 1)'(ttl_ff);
   assign exp_new = exp_sum[stt_pkg::TIME_W] ? '1 : exp_sum[stt_pkg::TIME_W-1:0];

   assign ram_re = (state_ff == stt_pkg::ST_SCAN) && (rd_cnt_ff < CNT_W'(SESSION_ENTRIES));

   stt_ram #(
      .WIDTH(stt_pkg::ENTRY_W),
      .DEPTH(SESSION_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rd_cnt_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   assign ent       = stt_pkg::entry_type'(ram_rdata);
   assign live_cur  = live_ff[chk_idx_ff];
   assign key_match = (ent.key_high == kh_ff) && (ent.key_low == kl_ff);
   assign expired   = ent.expiry < time_ff;
   assign last      = chk_idx_ff == LAST_IDX;

   // One entry is judged per cycle; the data belongs to chk_idx_ff.
   always_comb begin
      scan_done     = 1'b0;
      live_clr      = 1'b0;
      take_free     = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = chk_idx_ff;
      ram_wdata     = '{key_high: kh_ff, key_low: kl_ff, expiry: exp_ff,
                        role: role_ff, user: tag_ff};
      rsp_ok_scan   = 1'b0;
      rsp_role_scan = '0;
      rsp_tag_scan  = '0;
      slot_vld_in   = slot_vld_ff;
      slot_in       = slot_ff;
      if ((state_ff == stt_pkg::ST_SCAN) && chk_vld_ff) begin
         priority if (op_ff == stt_pkg::REQ_STORE) begin
            if (live_cur && key_match) begin
               scan_done   = 1'b1;
               ram_we      = 1'b1;
               rsp_ok_scan = 1'b1;
            end else begin
               // The last free or expired slot in scan order wins.
               take_free = !live_cur || expired;
               if (take_free) begin
                  slot_vld_in = 1'b1;
                  slot_in     = chk_idx_ff;
               end
               if (last) begin
                  scan_done = 1'b1;
                  if (take_free) begin
                     ram_we      = 1'b1;
                     rsp_ok_scan = 1'b1;
                  end else if (slot_vld_ff) begin
                     ram_we      = 1'b1;
                     ram_waddr   = slot_ff;
                     rsp_ok_scan = 1'b1;
                  end
               end
            end
         end else if (op_ff == stt_pkg::REQ_VALIDATE) begin
            if (live_cur && expired) begin
               live_clr = 1'b1;
            end else if (live_cur && key_match) begin
               scan_done        = 1'b1;
               ram_we           = 1'b1;
               ram_wdata        = ent;
               ram_wdata.expiry = exp_ff;
               rsp_ok_scan      = 1'b1;
               rsp_role_scan    = ent.role;
               rsp_tag_scan     = ent.user;
            end
            if (last) begin
               scan_done = 1'b1;
            end
         end else begin
            if (live_cur && key_match) begin
               scan_done   = 1'b1;
               live_clr    = 1'b1;
               rsp_ok_scan = 1'b1;
            end
            if (last) begin
               scan_done = 1'b1;
            end
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      rd_cnt_in  = rd_cnt_ff;
      chk_vld_in = chk_vld_ff;
      chk_idx_in = chk_idx_ff;
      time_in    = time_ff;
      live_in    = live_ff;
      rsp_load   = 1'b0;
      rsp_ok_in  = rsp_ok_ff;
      rsp_role_in = rsp_role_ff;
      rsp_tag_in = rsp_tag_ff;

      unique case (state_ff)
         stt_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_scan) begin
                  state_in   = stt_pkg::ST_SCAN;
                  rd_cnt_in  = '0;
                  chk_vld_in = 1'b0;
               end else begin
                  // Clear, tick, empty token and unused kinds answer at once.
                  rsp_load    = 1'b1;
                  rsp_ok_in   = 1'b0;
                  rsp_role_in = '0;
                  rsp_tag_in  = '0;
                  if (req_tuser == stt_pkg::REQ_CLEAR) begin
                     live_in = '0;
                  end
                  if ((req_tuser == stt_pkg::REQ_TICK) && (time_ff != '1)) begin
                     time_in = time_ff + stt_pkg::TIME_W'(1);
                  end
               end
            end
         end
         stt_pkg::ST_SCAN: begin
            chk_vld_in = ram_re;
            chk_idx_in = rd_cnt_ff[IDX_W-1:0];
            if (ram_re) begin
               rd_cnt_in = rd_cnt_ff + CNT_W'(1);
            end
            if (live_clr) begin
               live_in[chk_idx_ff] = 1'b0;
            end
            if (ram_we) begin
               live_in[ram_waddr] = 1'b1;
            end
            if (scan_done) begin
               state_in    = stt_pkg::ST_IDLE;
               rsp_load    = 1'b1;
               rsp_ok_in   = rsp_ok_scan;
               rsp_role_in = rsp_role_scan;
               rsp_tag_in  = rsp_tag_scan;
            end
         end
         default: begin
            state_in = stt_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_tready) || rsp_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stt_pkg::ST_IDLE;
         ttl_ff       <= stt_pkg::TTL_RESET;
         time_ff      <= '0;
         live_ff      <= '0;
         rd_cnt_ff    <= '0;
         chk_vld_ff   <= 1'b0;
         chk_idx_ff   <= '0;
         slot_vld_ff  <= 1'b0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_ff      <= time_in;
         live_ff      <= live_in;
         rd_cnt_ff    <= rd_cnt_in;
         chk_vld_ff   <= chk_vld_in;
         chk_idx_ff   <= chk_idx_in;
         slot_vld_ff  <= req_fire ? 1'b0 : slot_vld_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            ttl_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= req_tuser;
         kh_ff   <= req_kh;
         kl_ff   <= req_kl;
         role_ff <= req_role;
         tag_ff  <= req_tag;
         exp_ff  <= exp_new;
      end
      if (rsp_load) begin
         rsp_ok_ff   <= rsp_ok_in;
         rsp_role_ff <= rsp_role_in;
         rsp_tag_ff  <= rsp_tag_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_tag_ff, rsp_role_ff, rsp_ok_ff};

   // No new request may enter while the table is being scanned.
   a_no_accept_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == stt_pkg::ST_SCAN) |-> !req_tready)
      else $error("request accepted during scan");

   // A finished scan always presents a response on the next cycle.
   a_scan_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      scan_done |=> rsp_tvalid)
      else $error("scan finished without a response");

   // The entry RAM is only written by the scan sequencer.
   a_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == stt_pkg::ST_SCAN))
      else $error("entry RAM written outside a scan");

   // A clear leaves every entry free.
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_tuser == stt_pkg::REQ_CLEAR)) |=> (live_ff == '0))
      else $error("clear left live entries");

   // Internal time never runs backward.
   a_time_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (time_ff >= $past(time_ff)))
      else $error("time decreased");

endmodule

// ----- rtl/stt_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package dependencies.

module stt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/sv/session_table_checker.sv -----
// Checker for session_table_ttl: watches the request, response and register ports,
// keeps its own copy of the session table and compares every response field by field.
// Depends on stt_pkg for field widths and request kinds.

module session_table_checker #(
   parameter int SESSION_ENTRIES = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [167:0] req_tdata,
   input  logic [2:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [39:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [31:0]  csr_wdata,
   output int           errors,
   output int           outstanding,
   output int           replies_seen,
   output int           hits,
   output int           aged_out
);

   localparam logic [stt_pkg::TIME_W-1:0] TIME_LIMIT = '1;

   typedef struct packed {
      logic                      ok;
      logic [stt_pkg::ROLE_W-1:0] role;
      logic [stt_pkg::TAG_W-1:0]  tag;
   } session_reply_type;

   logic                       live     [SESSION_ENTRIES];
   logic [stt_pkg::KEY_W-1:0]  key_hi   [SESSION_ENTRIES];
   logic [stt_pkg::KEY_W-1:0]  key_lo   [SESSION_ENTRIES];
   logic [stt_pkg::TIME_W-1:0] expiry   [SESSION_ENTRIES];
   logic [stt_pkg::ROLE_W-1:0] role_mem [SESSION_ENTRIES];
   logic [stt_pkg::TAG_W-1:0]  user_mem [SESSION_ENTRIES];
   logic [stt_pkg::TIME_W-1:0] now;
   logic [stt_pkg::TTL_W-1:0]  ttl;
   session_reply_type          pending_replies [$];

   // The sum passes the time limit only when the time is close to it, and
   // then the expiry saturates at the limit.
   function automatic logic [stt_pkg::TIME_W-1:0] expiry_after_ttl();
      logic [stt_pkg::TIME_W:0] sum;
      sum = {1'b0, now} + (stt_pkg::TIME_W + 1)'(ttl);
      if (sum > {1'b0, TIME_LIMIT})
         return TIME_LIMIT;
      return sum[stt_pkg::TIME_W-1:0];
   endfunction

   task automatic session_op(input logic [2:0] kind, input logic [63:0] kh,
                             input logic [63:0] kl, input logic [1:0] new_role,
                             input logic [31:0] new_tag, output session_reply_type r);
      logic zero_key;
      logic found;
      int   slot;
      r = '0;
      zero_key = (kh == '0) && (kl == '0);
      found = 1'b0;
      slot = -1;
      case (kind)
         stt_pkg::REQ_STORE: if (!zero_key) begin
            // A live match wins; otherwise the last free or expired slot is taken.
            for (int i = 0; i < SESSION_ENTRIES; i++) begin
               if (!found) begin
                  if (live[i] && key_hi[i] == kh && key_lo[i] == kl) begin
                     slot = i;
                     found = 1'b1;
                  end else if (!live[i] || expiry[i] < now) begin
                     slot = i;
                  end
               end
            end
            if (slot >= 0) begin
               key_hi[slot]   = kh;
               key_lo[slot]   = kl;
               expiry[slot]   = expiry_after_ttl();
               role_mem[slot] = new_role;
               user_mem[slot] = new_tag;
               live[slot]     = 1'b1;
               r.ok = 1'b1;
            end
         end
         stt_pkg::REQ_VALIDATE: if (!zero_key) begin
            for (int i = 0; i < SESSION_ENTRIES; i++) begin
               if (!found && live[i]) begin
                  if (expiry[i] < now) begin
                     live[i] = 1'b0;
                     aged_out++;
                  end else if (key_hi[i] == kh && key_lo[i] == kl) begin
                     expiry[i] = expiry_after_ttl();
                     r.ok   = 1'b1;
                     r.role = role_mem[i];
                     r.tag  = user_mem[i];
                     found  = 1'b1;
                  end
               end
            end
         end
         stt_pkg::REQ_REMOVE: if (!zero_key) begin
            for (int i = 0; i < SESSION_ENTRIES; i++) begin
               if (!found && live[i] && key_hi[i] == kh && key_lo[i] == kl) begin
                  live[i] = 1'b0;
                  r.ok  = 1'b1;
                  found = 1'b1;
               end
            end
         end
         stt_pkg::REQ_CLEAR: begin
            for (int i = 0; i < SESSION_ENTRIES; i++)
               live[i] = 1'b0;
         end
         stt_pkg::REQ_TICK: begin
            if (now != TIME_LIMIT)
               now = now + stt_pkg::TIME_W'(1);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : monitor
      session_reply_type want;
      session_reply_type got;
      session_reply_type next_reply;
      if (reset) begin
         for (int i = 0; i < SESSION_ENTRIES; i++)
            live[i] = 1'b0;
         now = '0;
         ttl = stt_pkg::TTL_RESET;
         pending_replies.delete();
         outstanding = 0;
      end else begin
         if (csr_we)
            ttl = csr_wdata;
         // A response can never belong to a request accepted at the same edge,
         // so it is matched before the new request is added.
         if (rsp_tvalid && rsp_tready) begin
            got.ok   = rsp_tdata[0];
            got.role = rsp_tdata[2:1];
            got.tag  = rsp_tdata[34:3];
            if (pending_replies.size() == 0) begin
               $error("Response transaction arrived with no request pending.");
               errors++;
            end else begin
               want = pending_replies.pop_front();
               replies_seen++;
               if (want.ok)
                  hits++;
               if (got.ok !== want.ok) begin
                  $error("success mismatch: expected %0d, got %0d", want.ok, got.ok);
                  errors++;
               end
               if (got.role !== want.role) begin
                  $error("session_role mismatch: expected %0d, got %0d",
                         want.role, got.role);
                  errors++;
               end
               if (got.tag !== want.tag) begin
                  $error("out_user_tag mismatch: expected %h, got %h", want.tag, got.tag);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            session_op(req_tuser, req_tdata[63:0], req_tdata[127:64], req_tdata[129:128],
                       req_tdata[161:130], next_reply);
            pending_replies.push_back(next_reply);
         end
         outstanding = pending_replies.size();
      end
   end

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top for session_table_ttl: clock, reset, request and register stimulus,
// response back-pressure and the final verdict.
// Depends on stt_pkg, session_table_ttl and session_table_checker.

module tb_top;

   localparam int          SESSION_ENTRIES  = 8;
   localparam int          POOL             = 12;
   localparam int          RANDOM_PER_PHASE = 75;
   localparam int          PHASES           = 6;
   localparam int          LONG_HOLD        = 250;
   localparam int          SETTLE_CYCLES    = 2 * SESSION_ENTRIES + 4;
   localparam logic [2:0]  REQ_SPARE_FIRST  = 3'd5;
   localparam logic [2:0]  REQ_SPARE_LAST   = 3'd7;
   localparam logic [63:0] KEY_MSB          = 64'h8000_0000_0000_0000;
   localparam logic [63:0] KEY_ONES         = '1;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [167:0] req_tdata;
   logic [2:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [39:0]  rsp_tdata;
   logic         csr_we;
   logic [31:0]  csr_wdata;

   int           errors;
   int           outstanding;
   int           replies_seen;
   int           hits;
   int           aged_out;
   int           ttl_settings;
   int           calm_items;
   bit           hold_rsp;
   bit           hold_done;
   logic         req_taken;
   logic [63:0]  pool_hi [POOL];
   logic [63:0]  pool_lo [POOL];

   session_table_ttl #(
      .SESSION_ENTRIES(SESSION_ENTRIES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   session_table_checker #(
      .SESSION_ENTRIES(SESSION_ENTRIES)
   ) checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .errors       (errors),
      .outstanding  (outstanding),
      .replies_seen (replies_seen),
      .hits         (hits),
      .aged_out     (aged_out)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Records at each rising edge whether a request transaction was accepted.
   always @(posedge clock)
      req_taken <= req_tvalid && req_tready;

   // Offers one request transaction and returns at the falling edge after it
   // is accepted, or at the end of the idle gap that may follow, with tvalid low in it.
   task automatic push_req(input logic [2:0] kind, input logic [63:0] kh,
                           input logic [63:0] kl, input logic [1:0] role,
                           input logic [31:0] tag);
      int gap;
      int pick;
      req_tuser  = kind;
      req_tdata  = {6'd0, tag, role, kl, kh};
      req_tvalid = 1'b1;
      @(negedge clock);
      while (!req_taken)
         @(negedge clock);
      gap = 0;
      if (calm_items > 0) begin
         calm_items--;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 55)
            gap = 0;
         else if (pick < 85)
            gap = $urandom_range(1, 3);
         else if (pick < 95)
            calm_items = $urandom_range(10, 30);
         else
            gap = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic settle();
      req_tvalid = 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_ttl(input logic [31:0] value);
      settle();
      csr_wdata = value;
      csr_we    = 1'b1;
      @(negedge clock);
      csr_we    = 1'b0;
      ttl_settings++;
   endtask

   // Keys come in groups of three: a base key, one sharing its upper half and
   // one sharing its lower half, so each half of the comparison is exercised.
   task automatic fill_pool();
      for (int i = 0; i < POOL; i++) begin
         pool_hi[i] = {$urandom, $urandom};
         pool_lo[i] = {$urandom, $urandom};
         if (i % 3 == 1)
            pool_hi[i] = pool_hi[i-1];
         else if (i % 3 == 2)
            pool_lo[i] = pool_lo[i-2];
         if (pool_hi[i] == '0 && pool_lo[i] == '0)
            pool_lo[i] = 64'd1;
      end
   endtask

   task automatic pick_token(output logic [63:0] kh, output logic [63:0] kl);
      int pick;
      int idx;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         kh = '0;
         kl = '0;
      end else if (pick < 8) begin
         kh = KEY_ONES;
         kl = KEY_ONES;
      end else if (pick < 15) begin
         kh = {$urandom, $urandom};
         kl = {$urandom, $urandom};
      end else begin
         idx = $urandom_range(0, POOL - 1);
         kh = pool_hi[idx];
         kl = pool_lo[idx];
      end
   endtask

   initial begin : receiver
      int pick;
      int len;
      rsp_tready = 1'b0;
      hold_done  = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (hold_rsp && !hold_done) begin
            // Long hold-off so the output register fills and the input stalls.
            rsp_tready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_done = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            rsp_tready = 1'b1;
            len = $urandom_range(1, 40);
         end else if (pick < 95) begin
            rsp_tready = 1'b0;
            len = $urandom_range(1, 3);
         end else begin
            rsp_tready = 1'b0;
            len = $urandom_range(10, 40);
         end
         repeat (len) @(negedge clock);
      end
   end

   initial begin : stimulus
      logic [63:0] kh;
      logic [63:0] kl;
      logic [2:0]  kind;
      logic [31:0] ttl_plan [PHASES];
      int          counted;
      int          pick;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      hold_rsp   = 1'b0;
      calm_items = 0;
      ttl_settings = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset lifetime: empty table, zero tokens, refresh,
      // keys matching in one half only, remove, unused kinds, tick and clear.
      push_req(stt_pkg::REQ_VALIDATE, KEY_MSB, '0, 2'd0, 32'd0);
      push_req(stt_pkg::REQ_STORE, '0, '0, 2'd3, '1);
      push_req(stt_pkg::REQ_VALIDATE, '0, '0, 2'd0, 32'd0);
      push_req(stt_pkg::REQ_REMOVE, '0, '0, 2'd0, 32'd0);
      push_req(stt_pkg::REQ_STORE, KEY_MSB, '0, 2'd3, '1);
      push_req(stt_pkg::REQ_STORE, KEY_ONES, KEY_ONES, 2'd0, 32'd0);
      push_req(stt_pkg::REQ_VALIDATE, KEY_MSB, '0, 2'd0, 32'd0);
      push_req(stt_pkg::REQ_VALIDATE, KEY_MSB, 64'd1, 2'd0, 32'd0);
      push_req(stt_pkg::REQ_VALIDATE, 64'd1, '0, 2'd0, 32'd0);
      push_req(stt_pkg::REQ_STORE, KEY_MSB, '0, 2'd1, 32'h1234_5678);
      push_req(stt_pkg::REQ_VALIDATE, KEY_MSB, '0, 2'd2, '1);
      push_req(stt_pkg::REQ_REMOVE, KEY_ONES, KEY_ONES, 2'd0, 32'd0);
      push_req(stt_pkg::REQ_REMOVE, KEY_ONES, KEY_ONES, 2'd0, 32'd0);
      push_req(REQ_SPARE_FIRST, KEY_MSB, '0, 2'd3, '1);
      push_req(REQ_SPARE_FIRST + 3'd1, KEY_MSB, '0, 2'd3, '1);
      push_req(REQ_SPARE_LAST, KEY_MSB, '0, 2'd3, '1);
      push_req(stt_pkg::REQ_TICK, KEY_ONES, KEY_ONES, 2'd3, '1);
      push_req(stt_pkg::REQ_CLEAR, KEY_ONES, KEY_ONES, 2'd3, '1);
      push_req(stt_pkg::REQ_VALIDATE, KEY_MSB, '0, 2'd0, 32'd0);

      // Zero lifetime: an entry expires on the next tick, yet store and remove
      // still take a live match that has expired.
      write_ttl(32'd0);
      push_req(stt_pkg::REQ_STORE, KEY_MSB, '0, 2'd2, 32'hA5A5_0001);
      push_req(stt_pkg::REQ_TICK, '0, '0, 2'd0, 32'd0);
      push_req(stt_pkg::REQ_VALIDATE, KEY_MSB, '0, 2'd0, 32'd0);
      push_req(stt_pkg::REQ_STORE, KEY_ONES, KEY_ONES, 2'd1, 32'hA5A5_0002);
      push_req(stt_pkg::REQ_TICK, '0, '0, 2'd0, 32'd0);
      push_req(stt_pkg::REQ_REMOVE, KEY_ONES, KEY_ONES, 2'd0, 32'd0);
      push_req(stt_pkg::REQ_STORE, KEY_MSB, '0, 2'd3, 32'hA5A5_0003);
      push_req(stt_pkg::REQ_TICK, '0, '0, 2'd0, 32'd0);
      push_req(stt_pkg::REQ_STORE, KEY_MSB, '0, 2'd0, 32'hA5A5_0004);

      ttl_plan = '{32'hFFFF_FFFF, 32'd1, 32'd3, 32'($urandom_range(2, 12)), 32'd0, $urandom};
      for (int phase = 0; phase < PHASES; phase++) begin
         write_ttl(ttl_plan[phase]);
         fill_pool();
         if (phase == 1)
            hold_rsp = 1'b1;
         counted = 0;
         while (counted < RANDOM_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
               kind = stt_pkg::REQ_STORE;
            else if (pick < 58)
               kind = stt_pkg::REQ_VALIDATE;
            else if (pick < 70)
               kind = stt_pkg::REQ_REMOVE;
            else if (pick < 90)
               kind = stt_pkg::REQ_TICK;
            else if (pick < 93)
               kind = stt_pkg::REQ_CLEAR;
            else
               kind = REQ_SPARE_FIRST + 3'($urandom_range(0, 2));
            pick_token(kh, kl);
            push_req(kind, kh, kl, 2'($urandom_range(0, 3)), $urandom);
            // Ignored transactions do not count toward the phase length.
            if (kind <= stt_pkg::REQ_TICK &&
                !(kind <= stt_pkg::REQ_REMOVE && kh == '0 && kl == '0))
               counted++;
         end
      end

      settle();
      $display("Checked %0d responses, %0d of them successful, over %0d lifetime settings.",
               replies_seen, hits, ttl_settings);
      $display("Validation aged out %0d entries; the response side stalled once for %0d cycles.",
               aged_out, LONG_HOLD);
      if (errors == 0 && outstanding == 0)
         $display("session_table_ttl test passed");
      else
         $display("session_table_ttl test failed");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("session_table_ttl test failed");
      $finish;
   end

endmodule
